// File: rtl/pfdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer flush package
// Shared types, codes and defaults for the paged framebuffer with dirty
// tracking and incremental panel flush.
// ----------------------------------------------------------------------------
package pfdf_pkg;

	// Default geometry of the panel.
	localparam int COLUMNS_DEF = 128;
	localparam int PAGES_DEF   = 8;

	// Widths that cover the whole supported geometry range.
	localparam int IDX_W_MAX  = 12;
	localparam int COL_W_MAX  = 8;
	localparam int PAGE_W_MAX = 4;

	// Request opcodes.
	typedef enum logic [1:0] {
		MODE_SET   = 2'd0,
		MODE_GET   = 2'd1,
		MODE_FLUSH = 2'd2
	} mode_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_PIXEL = 2'd2
	} kind_t;

	// Panel command bytes.
	localparam logic [7:0] CMD_PAGE    = 8'hB0;
	localparam logic [7:0] CMD_COL_LO  = 8'h00;
	localparam logic [7:0] CMD_COL_HI  = 8'h10;
	localparam logic [7:0] NIBBLE_MASK = 8'h0F;
	localparam logic [7:0] PIXEL_ON    = 8'h01;

	// Result slots of one request, emitted in this order.
	localparam int SLOTS         = 7;
	localparam int SLOT_HDR_PAGE = 0;
	localparam int SLOT_HDR_LO   = 1;
	localparam int SLOT_HDR_HI   = 2;
	localparam int SLOT_POS_PAGE = 3;
	localparam int SLOT_POS_LO   = 4;
	localparam int SLOT_POS_HI   = 5;
	localparam int SLOT_DATA     = 6;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		mode_t                  op;
		logic [IDX_W_MAX-1:0]   idx;
		logic [PAGE_W_MAX-1:0]  page;
		logic [COL_W_MAX-1:0]   col;
		logic [2:0]             bsel;
		logic                   color;
		logic                   in_panel;
		logic                   col_zero;
		logic                   pos_zero;
	} job_t;

endpackage

// File: rtl/pfdf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfdf_ram import pfdf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = COLUMNS_DEF * PAGES_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/pfdf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request queue
// Two-entry queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module pfdf_queue import pfdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/pfdf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, checks bounds, computes byte addresses and tracks the
// flush scan position, then queues the classified request.
// ----------------------------------------------------------------------------
module pfdf_front import pfdf_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int PAGES   = PAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] mode,
	input  logic [6:0] x,
	input  logic [5:0] y,
	input  logic       color,
	input  logic       q_full,
	input  logic       clearing,
	output logic       q_push,
	output job_t       q_job
);

	localparam int CELLS = COLUMNS * PAGES;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

	logic [AW-1:0] scan_idx_q;
	logic [CW-1:0] scan_col_q;
	logic [PW-1:0] scan_page_q;

	logic                 accept;
	logic                 keep;
	logic [2:0]           pg;
	logic                 in_panel;
	logic [IDX_W_MAX-1:0] pix_idx;

	// No new request while the queue is full or the store is being cleared.
	assign req_stall = q_full | clearing;
	assign accept    = req_valid & ~req_stall;
	assign q_push    = accept & keep;

	// Pixel address and bounds check.
	assign pg       = y[5:3];
	assign in_panel = ({2'b00, x} < 9'(COLUMNS)) && ({2'b00, pg} < 5'(PAGES));
	assign pix_idx  = IDX_W_MAX'(pg) * IDX_W_MAX'(COLUMNS) + IDX_W_MAX'(x);

	// Classify the request.
	always_comb begin
		keep           = 1'b0;
		q_job.op       = MODE_SET;
		q_job.idx      = pix_idx;
		q_job.page     = PAGE_W_MAX'(pg);
		q_job.col      = COL_W_MAX'(x);
		q_job.bsel     = y[2:0];
		q_job.color    = color;
		q_job.in_panel = in_panel;
		q_job.col_zero = 1'b0;
		q_job.pos_zero = 1'b0;
		case (mode)
			MODE_SET: begin
				keep = in_panel;
			end
			MODE_GET: begin
				keep     = 1'b1;
				q_job.op = MODE_GET;
			end
			MODE_FLUSH: begin
				keep           = 1'b1;
				q_job.op       = MODE_FLUSH;
				q_job.idx      = IDX_W_MAX'(scan_idx_q);
				q_job.page     = PAGE_W_MAX'(scan_page_q);
				q_job.col      = COL_W_MAX'(scan_col_q);
				q_job.col_zero = (scan_col_q == '0);
				q_job.pos_zero = (scan_idx_q == '0);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Flush scan position, page-major with wrap after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			scan_col_q  <= '0;
			scan_page_q <= '0;
		end else if (accept && (mode == MODE_FLUSH)) begin
			if (scan_idx_q == AW'(CELLS - 1)) begin
				scan_idx_q  <= '0;
				scan_col_q  <= '0;
				scan_page_q <= '0;
			end else begin
				scan_idx_q <= scan_idx_q + AW'(1);
				if (scan_col_q == CW'(COLUMNS - 1)) begin
					scan_col_q  <= '0;
					scan_page_q <= scan_page_q + PW'(1);
				end else begin
					scan_col_q <= scan_col_q + CW'(1);
				end
			end
		end
	end

endmodule

// File: rtl/pfdf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Owns the pixel/dirty store and the shadow store. Runs the clearing pass,
// performs byte read-modify-writes and streams result bytes one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pfdf_back import pfdf_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int PAGES   = PAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_job,
	output logic       q_pop,
	output logic       clearing,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] byte_value,
	output logic       last
);

	localparam int CELLS = COLUMNS * PAGES;
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic             run_q;
	logic [SLOTS-1:0] slot_q;
	job_t             cur_q;
	logic [7:0]       data_q;
	logic             res_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       byte_q;
	logic             last_q;

	// Store ports: the main word is {dirty mark, pixel byte}.
	logic          main_we;
	logic [AW-1:0] main_wa;
	logic [8:0]    main_wd;
	logic [8:0]    main_rd;
	logic          shd_we;
	logic [7:0]    shd_rd;
	logic          rd_en;

	logic             cur_dirty;
	logic [7:0]       cur_pix;
	logic [7:0]       mask;
	logic [7:0]       set_pix;
	logic             set_dirty;
	logic             run_base;
	logic [SLOTS-1:0] slots_new;
	logic [7:0]       data_new;
	logic             out_free;
	logic [SLOTS-1:0] sel;
	logic             is_last;
	logic [1:0]       em_kind;
	logic [7:0]       em_byte;

	// Byte of a result slot.
	function automatic logic [7:0] slot_byte(input int s, input job_t j,
			input logic [7:0] d);
		logic [7:0] b;
		case (s)
			SLOT_HDR_PAGE: b = CMD_PAGE + 8'(j.page);
			SLOT_HDR_LO:   b = CMD_COL_LO;
			SLOT_HDR_HI:   b = CMD_COL_HI;
			SLOT_POS_PAGE: b = CMD_PAGE + 8'(j.page);
			SLOT_POS_LO:   b = CMD_COL_LO + (8'(j.col) & NIBBLE_MASK);
			SLOT_POS_HI:   b = CMD_COL_HI + ((8'(j.col) >> 4) & NIBBLE_MASK);
			SLOT_DATA:     b = d;
			default:       b = '0;
		endcase
		return b;
	endfunction

	pfdf_ram #(
		.WIDTH (9),
		.DEPTH (CELLS)
	) u_main_ram (
		.clk     (clk),
		.wr_en   (main_we),
		.wr_addr (main_wa),
		.wr_data (main_wd),
		.rd_en   (rd_en),
		.rd_addr (q_job.idx[AW-1:0]),
		.rd_data (main_rd)
	);

	pfdf_ram #(
		.WIDTH (8),
		.DEPTH (CELLS)
	) u_shadow_ram (
		.clk     (clk),
		.wr_en   (shd_we),
		.wr_addr (cur_q.idx[AW-1:0]),
		.wr_data (cur_pix),
		.rd_en   (rd_en),
		.rd_addr (q_job.idx[AW-1:0]),
		.rd_data (shd_rd)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign rd_en    = (state_q == ST_IDLE) && !q_empty;
	assign q_pop    = rd_en;

	// Byte update for the request that was read last cycle.
	assign cur_dirty = main_rd[8];
	assign cur_pix   = main_rd[7:0];
	assign mask      = 8'h01 << cur_q.bsel;
	assign set_pix   = cur_q.color ? (cur_pix | mask) : (cur_pix & ~mask);
	assign set_dirty = cur_dirty | (set_pix != shd_rd);
	assign run_base  = cur_q.pos_zero ? 1'b0 : run_q;

	// Store writes: clearing pass, pixel update or flush of a dirty byte.
	always_comb begin
		main_we = 1'b0;
		main_wa = clr_q;
		main_wd = {1'b1, 8'h00};
		shd_we  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				main_we = 1'b1;
			end
			ST_READ: begin
				main_wa = cur_q.idx[AW-1:0];
				case (cur_q.op)
					MODE_SET: begin
						main_we = cur_q.in_panel;
						main_wd = {set_dirty, set_pix};
					end
					MODE_FLUSH: begin
						main_we = cur_dirty;
						main_wd = {1'b0, cur_pix};
						shd_we  = cur_dirty;
					end
					default: begin
						main_we = 1'b0;
					end
				endcase
			end
			default: begin
				main_we = 1'b0;
			end
		endcase
	end

	// Which results the request produces.
	always_comb begin
		slots_new = '0;
		data_new  = cur_pix;
		case (cur_q.op)
			MODE_GET: begin
				slots_new[SLOT_DATA] = 1'b1;
				data_new = (cur_q.in_panel && ((cur_pix & mask) != 8'h00)) ? PIXEL_ON : 8'h00;
			end
			MODE_FLUSH: begin
				slots_new[SLOT_HDR_PAGE] = cur_q.col_zero;
				slots_new[SLOT_HDR_LO]   = cur_q.col_zero;
				slots_new[SLOT_HDR_HI]   = cur_q.col_zero;
				slots_new[SLOT_POS_PAGE] = cur_dirty & ~run_base;
				slots_new[SLOT_POS_LO]   = cur_dirty & ~run_base;
				slots_new[SLOT_POS_HI]   = cur_dirty & ~run_base;
				slots_new[SLOT_DATA]     = cur_dirty;
			end
			default: begin
				slots_new = '0;
			end
		endcase
	end

	// Next pending slot and its contents.
	assign out_free = !res_valid_q || !res_stall;
	assign sel      = slot_q & (~slot_q + SLOTS'(1));
	assign is_last  = ((slot_q & ~sel) == '0);

	always_comb begin
		em_kind = KIND_CMD;
		em_byte = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (sel[i]) begin
				em_byte = slot_byte(i, cur_q, data_q);
				if (i == SLOT_DATA) begin
					em_kind = (cur_q.op == MODE_GET) ? KIND_PIXEL : KIND_DATA;
				end else begin
					em_kind = KIND_CMD;
				end
			end
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			run_q       <= 1'b0;
			slot_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// A taken result drops its request unless the next byte replaces it.
			if (res_valid_q && !res_stall && (state_q != ST_EMIT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						cur_q   <= q_job;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					data_q <= data_new;
					slot_q <= slots_new;
					if (cur_q.op == MODE_FLUSH) begin
						run_q <= cur_dirty;
					end
					state_q <= (slots_new != '0) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						kind_q      <= em_kind;
						byte_q      <= em_byte;
						last_q      <= is_last;
						slot_q      <= slot_q & ~sel;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign kind       = kind_q;
	assign byte_value = byte_q;
	assign last       = last_q;

endmodule

// File: rtl/page_framebuffer_dirty_flush.sv
`timescale 1ns / 1ps
// The back end handles one request at a time: a byte read-modify-write, then
// its result bytes (up to 7 for a flush step) on the single result port.
// Reset: asynchronous; afterwards a clearing pass writes all COLUMNS*PAGES
// store entries (1024 by default), during which req_stall stays high.
// ----------------------------------------------------------------------------
// Page framebuffer with dirty flush
// Monochrome paged framebuffer with per-byte dirty marks and an incremental
// flush that emits panel command and data bytes.
// ----------------------------------------------------------------------------
module page_framebuffer_dirty_flush import pfdf_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int PAGES   = PAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] mode,
	input  logic [6:0] x,
	input  logic [5:0] y,
	input  logic       color,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] byte_value,
	output logic       last
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	logic clearing;
	job_t push_job;
	job_t head_job;

	// Front end: accept and classify.
	pfdf_front #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.mode      (mode),
		.x         (x),
		.y         (y),
		.color     (color),
		.q_full    (q_full),
		.clearing  (clearing),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	// Queue between the two halves.
	pfdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	// Back end: store access and result stream.
	pfdf_back #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (head_job),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.byte_value (byte_value),
		.last       (last)
	);

endmodule

// File: rtl/pfdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Concurrent assertions on the result port of the framebuffer block.
// ----------------------------------------------------------------------------
module pfdf_port_checks import pfdf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] kind,
	input logic [7:0] byte_value,
	input logic       last
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(kind) && $stable(byte_value) && $stable(last))
		else $error("result payload changed while stalled");

	// A pixel answer is a single bit and closes its request.
	a_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_PIXEL) |-> last && (byte_value[7:1] == 7'd0))
		else $error("malformed pixel answer");

	// A data byte always closes its flush step.
	a_data_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_DATA) |-> last)
		else $error("data byte not last of its flush step");

	// Results of one request follow without gaps.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last |=> res_valid)
		else $error("gap inside a result burst");

endmodule

bind page_framebuffer_dirty_flush pfdf_port_checks u_port_checks (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.kind       (kind),
	.byte_value (byte_value),
	.last       (last)
);

// File: bench/pfdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer flush checker
// Watches the request and result channels of the framebuffer, keeps its own
// copy of the pixel store, panel shadow, dirty marks and scan state, and
// compares every accepted result byte with the oldest predicted one.
// ----------------------------------------------------------------------------
module pfdf_checker import pfdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  logic [1:0] mode,
	input  logic [6:0] x,
	input  logic [5:0] y,
	input  logic       color,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic [1:0] kind,
	input  logic [7:0] byte_value,
	input  logic       last,
	output int         misses,
	output int         waiting
);

	localparam int CELLS = COLUMNS_DEF * PAGES_DEF;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} panel_out_t;

	// Mirror of the block state.
	logic [7:0] frame_bytes [CELLS];
	logic [7:0] shown_bytes [CELLS];
	logic       dirty_mark [CELLS];
	int         scan_at;
	logic       run_live;

	// Results still owed by the block, oldest first.
	panel_out_t out_due [$];
	panel_out_t burst [SLOTS];
	panel_out_t want;
	int         burst_n;
	int         mismatches = 0;

	task automatic stage(input kind_t k, input logic [7:0] v);
		burst[burst_n] = '{kind: k, value: v, last: 1'b0};
		burst_n++;
	endtask

	// Work out the result bytes of one accepted request and update the mirror.
	task automatic predict_request(input logic [1:0] op, input logic [6:0] px,
			input logic [5:0] py, input logic pc);
		int         page;
		int         col;
		int         idx;
		logic [7:0] v;
		logic       in_panel;
		burst_n = 0;
		page = int'(py) / 8;
		in_panel = (int'(px) < COLUMNS_DEF) && (page < PAGES_DEF);
		idx = page * COLUMNS_DEF + int'(px);
		case (op)
			MODE_SET: begin
				if (in_panel) begin
					v = frame_bytes[idx];
					v[py[2:0]] = pc;
					frame_bytes[idx] = v;
					// A byte that is already marked stays marked.
					if (v != shown_bytes[idx])
						dirty_mark[idx] = 1'b1;
				end
			end
			MODE_GET: begin
				if (in_panel && frame_bytes[idx][py[2:0]])
					stage(KIND_PIXEL, PIXEL_ON);
				else
					stage(KIND_PIXEL, 8'h00);
			end
			MODE_FLUSH: begin
				page = scan_at / COLUMNS_DEF;
				col = scan_at % COLUMNS_DEF;
				// A new pass starts with no open run.
				if (scan_at == 0)
					run_live = 1'b0;
				if (col == 0) begin
					stage(KIND_CMD, CMD_PAGE + 8'(page));
					stage(KIND_CMD, CMD_COL_LO);
					stage(KIND_CMD, CMD_COL_HI);
				end
				if (dirty_mark[scan_at]) begin
					if (!run_live) begin
						stage(KIND_CMD, CMD_PAGE + 8'(page));
						stage(KIND_CMD, CMD_COL_LO + (8'(col) & NIBBLE_MASK));
						stage(KIND_CMD, CMD_COL_HI + (8'(col >> 4) & NIBBLE_MASK));
						run_live = 1'b1;
					end
					stage(KIND_DATA, frame_bytes[scan_at]);
					shown_bytes[scan_at] = frame_bytes[scan_at];
					dirty_mark[scan_at] = 1'b0;
				end else begin
					run_live = 1'b0;
				end
				scan_at = (scan_at + 1) % CELLS;
			end
			default: begin
			end
		endcase
		if (burst_n > 0)
			burst[burst_n - 1].last = 1'b1;
		for (int i = 0; i < burst_n; i++)
			out_due.push_back(burst[i]);
	endtask

	// Compare results first, then record the request taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				frame_bytes[i] = 8'h00;
				shown_bytes[i] = 8'h00;
				dirty_mark[i] = 1'b1;
			end
			scan_at = 0;
			run_live = 1'b0;
			out_due.delete();
			misses <= mismatches;
			waiting <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (out_due.size() == 0) begin
					$display("%0t: unexpected result, kind %0d byte %02h last %0b",
						$time, kind, byte_value, last);
					mismatches++;
				end else begin
					want = out_due.pop_front();
					if (kind !== want.kind) begin
						$display("%0t: kind mismatch, expected %0d, got %0d",
							$time, want.kind, kind);
						mismatches++;
					end
					if (byte_value !== want.value) begin
						$display("%0t: byte_value mismatch, expected %02h, got %02h",
							$time, want.value, byte_value);
						mismatches++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch, expected %0b, got %0b",
							$time, want.last, last);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall)
				predict_request(mode, x, y, color);
			misses <= mismatches;
			waiting <= out_due.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer flush testbench
// Drives directed and random pixel, read and flush requests with random gaps
// and result stalls, and reports the verdict from the checker's mismatch
// count.
// ----------------------------------------------------------------------------
module tb;
	import pfdf_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int         CELLS     = COLUMNS_DEF * PAGES_DEF;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	logic [1:0] mode;
	logic [6:0] x;
	logic [5:0] y;
	logic       color;
	logic       res_valid;
	logic       res_stall;
	logic [1:0] kind;
	logic [7:0] byte_value;
	logic       last;

	int         misses;
	int         waiting;
	int         scan_next;
	int         pick;
	int         taken;
	bit         held;
	bit         calm;
	logic [6:0] ax;
	logic [5:0] ay;

	page_framebuffer_dirty_flush u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.mode       (mode),
		.x          (x),
		.y          (y),
		.color      (color),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.byte_value (byte_value),
		.last       (last)
	);

	pfdf_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.mode       (mode),
		.x          (x),
		.y          (y),
		.color      (color),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.byte_value (byte_value),
		.last       (last),
		.misses     (misses),
		.waiting    (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request, with an occasional gap before it, and hold it until taken.
	task automatic offer(input logic [1:0] op, input logic [6:0] px, input logic [5:0] py,
			input logic pc);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= op;
		x <= px;
		y <= py;
		color <= pc;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (op == MODE_FLUSH)
			scan_next = (scan_next + 1) % CELLS;
	endtask

	// Hold off requests until every predicted result has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
	endtask

	// Pick a pixel in a byte just behind or ahead of the flush position.
	task automatic aim_near(output logic [6:0] px, output logic [5:0] py);
		int p;
		p = (scan_next + CELLS - 3 + $urandom_range(0, 13)) % CELLS;
		px = 7'(p % COLUMNS_DEF);
		py = 6'((p / COLUMNS_DEF) * 8 + $urandom_range(0, 7));
	endtask

	// Result side: random stall bursts, and one long hold-off part way through.
	initial begin
		res_stall <= 1'b0;
		taken = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				taken++;
			if (taken >= 30 && !held) begin
				held = 1'b1;
				res_stall <= 1'b1;
				repeat (400) @(posedge clk);
				res_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Request side and verdict.
	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		mode <= MODE_SET;
		x <= 7'd0;
		y <= 6'd0;
		color <= 1'b0;
		calm = 1'b0;
		scan_next = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests: corners, every opcode, the ignored opcode, and
		// marks that stay set or stay clear.
		offer(MODE_GET, 7'd0, 6'd0, 1'b1);
		offer(MODE_NONE, 7'd127, 6'd63, 1'b1);
		offer(MODE_SET, 7'd0, 6'd0, 1'b1);
		offer(MODE_GET, 7'd0, 6'd0, 1'b0);
		offer(MODE_SET, 7'd127, 6'd63, 1'b1);
		offer(MODE_GET, 7'd127, 6'd63, 1'b0);
		offer(MODE_SET, 7'd85, 6'd42, 1'b1);
		offer(MODE_SET, 7'd42, 6'd21, 1'b1);
		offer(MODE_GET, 7'd42, 6'd21, 1'b0);
		offer(MODE_GET, 7'd85, 6'd42, 1'b1);
		offer(MODE_SET, 7'd127, 6'd63, 1'b0);
		offer(MODE_GET, 7'd127, 6'd63, 1'b1);
		offer(MODE_FLUSH, 7'd127, 6'd63, 1'b1);
		offer(MODE_FLUSH, 7'd0, 6'd0, 1'b0);
		// Byte 0 is clean now: change it and set it back, the mark must stay.
		offer(MODE_SET, 7'd0, 6'd0, 1'b0);
		offer(MODE_SET, 7'd0, 6'd0, 1'b1);
		// Writing the value the panel already shows leaves a clean byte clean.
		offer(MODE_SET, 7'd1, 6'd0, 1'b0);
		offer(MODE_NONE, 7'd0, 6'd0, 1'b0);
		offer(MODE_FLUSH, 7'd85, 6'd42, 1'b0);
		offer(MODE_FLUSH, 7'd42, 6'd21, 1'b1);
		wait_drained();

		// Random mix with writes landing near the flush position.
		for (int i = 0; i < 190; i++) begin
			if (i == 100)
				wait_drained();
			if (i == 160)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			aim_near(ax, ay);
			if (pick < 35)
				offer(MODE_SET, ax, ay, 1'($urandom_range(0, 1)));
			else if (pick < 45)
				offer(MODE_SET, 7'($urandom), 6'($urandom), 1'($urandom));
			else if (pick < 55)
				offer(MODE_GET, ax, ay, 1'($urandom));
			else if (pick < 62)
				offer(MODE_GET, 7'($urandom), 6'($urandom), 1'($urandom));
			else if (pick < 95)
				offer(MODE_FLUSH, 7'($urandom), 6'($urandom), 1'($urandom));
			else
				offer(MODE_NONE, 7'($urandom), 6'($urandom), 1'($urandom));
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (misses == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/pfdf_pkg.sv
rtl/pfdf_ram.sv
rtl/pfdf_queue.sv
rtl/pfdf_front.sv
rtl/pfdf_back.sv
rtl/page_framebuffer_dirty_flush.sv
rtl/pfdf_checker.sv
bench/pfdf_checker.sv
bench/tb.sv
